FILE: src/tbrl_pkg.sv
// ----------------------------------------------------------------------------
// tbrl_pkg: token bucket rate limiter shared definitions
// Field widths, register indexes, status codes, reset values and the
// control structs between the top level and the serial multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tbrl_pkg;

   // field widths
   localparam int OP_W     = 1;
   localparam int REQ_W    = 20;
   localparam int NOW_W    = 48;
   localparam int RATE_W   = 40;
   localparam int CAP_W    = 20;
   localparam int STATUS_W = 2;
   localparam int DELAY_W  = 56;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 40;

   // serial multiply/divide unit widths
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 40;
   localparam int DIV_W   = 40;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int CNT_W   = 7;

   // operation codes
   localparam logic [OP_W-1:0] OP_CONSUME = 1'b0;
   localparam logic [OP_W-1:0] OP_RESTART = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_WAIT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REFILL_RATE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_CAPACITY = 1'b1;

   // register reset values
   localparam logic [RATE_W-1:0] RATE_RESET = 40'd65536000;
   localparam logic [CAP_W-1:0]  CAP_RESET  = 20'd1000;

   localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

   // command to the multiply/divide unit: floor(a * b / d)
   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
      logic [DIV_W-1:0]   d;
   } mdv_cmd_type;

   // status back from the multiply/divide unit
   typedef struct packed {
      logic done;
      logic rem_nz;
   } mdv_status_type;

endpackage

`default_nettype wire

FILE: src/tbrl_if.sv
// ----------------------------------------------------------------------------
// tbrl interfaces: request, response and register write channels
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbrl_req_if;
   logic                          valid;
   logic                          ready;
   logic [tbrl_pkg::OP_W-1:0]     operation;
   logic [tbrl_pkg::REQ_W-1:0]    request_tokens;
   logic [tbrl_pkg::NOW_W-1:0]    now_us;

   modport source (output valid, output operation, output request_tokens,
                   output now_us, input ready);
   modport sink   (input valid, input operation, input request_tokens,
                   input now_us, output ready);
endinterface

interface tbrl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tbrl_pkg::STATUS_W-1:0] status;
   logic [tbrl_pkg::DELAY_W-1:0]  delay_us;

   modport source (output valid, output status, output delay_us, input ready);
   modport sink   (input valid, input status, input delay_us, output ready);
endinterface

interface tbrl_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tbrl_pkg::CSR_IDX_W-1:0]  index;
   logic [tbrl_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/tbrl_muldiv.sv
// ----------------------------------------------------------------------------
// tbrl_muldiv: bit-serial multiply then divide
// Computes floor(a * b / d) with a shift-add multiply, one multiplier bit a
// cycle, followed by a restoring divide, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbrl_muldiv (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tbrl_pkg::mdv_cmd_type       cmd,
   output tbrl_pkg::mdv_status_type         sts,
   output logic [tbrl_pkg::PROD_W-1:0]      quot
);
   import tbrl_pkg::*;

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_type;

   md_state_type       state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [MUL_A_W-1:0] a_ff;
   logic [DIV_W-1:0]   d_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [DIV_W-1:0]   rem_ff;
   logic               done_ff;

   logic [MUL_A_W:0]   mul_sum;
   logic [DIV_W:0]     div_trial;
   logic [DIV_W:0]     div_diff;
   logic               div_fit;

   // one multiply step and one divide step
   always_comb begin
      mul_sum   = {1'b0, prod_ff[PROD_W-1:MUL_B_W]}
                + (prod_ff[0] ? {1'b0, a_ff} : {(MUL_A_W+1){1'b0}});
      div_trial = {rem_ff, prod_ff[PROD_W-1]};
      div_fit   = div_trial >= {1'b0, d_ff};
      div_diff  = div_trial - {1'b0, d_ff};
   end

   // sequencer, product/quotient shift register and remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= (state_ff == MD_DIV) && (cnt_ff == '0);
         unique case (state_ff)
            MD_IDLE: begin
               if (cmd.start) begin
                  a_ff     <= cmd.a;
                  d_ff     <= cmd.d;
                  prod_ff  <= PROD_W'(cmd.b);
                  rem_ff   <= '0;
                  cnt_ff   <= CNT_W'(MUL_B_W - 1);
                  state_ff <= MD_MUL;
               end
            end
            MD_MUL: begin
               prod_ff <= {mul_sum, prod_ff[MUL_B_W-1:1]};
               if (cnt_ff == '0) begin
                  cnt_ff   <= CNT_W'(PROD_W - 1);
                  state_ff <= MD_DIV;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            MD_DIV: begin
               prod_ff <= {prod_ff[PROD_W-2:0], div_fit};
               rem_ff  <= div_fit ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];
               if (cnt_ff == '0) begin
                  state_ff <= MD_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: state_ff <= MD_IDLE;
         endcase
      end
   end

   assign quot       = prod_ff;
   assign sts.done   = done_ff;
   assign sts.rem_nz = |rem_ff;

endmodule

`default_nettype wire

FILE: src/token_bucket_rate_limiter.sv
// Path: a restart or a bad count goes from accept through the evaluate state
// to the response register, a grant from a full bucket also through the check
// state; a refill pass and a wait-time pass through the serial unit may be added.
// Throughput: one word at a time, the next taken the cycle after a response
// is loaded; the serial unit (40 multiply plus 88 divide steps) sets it.
// Reset: bucket full at 1000 tokens, last grant time 0, rate 1000 tokens/s.
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter: fixed point token bucket admission control
// Refills the bucket from elapsed time, grants or rejects consume words and
// returns the wait time in microseconds for rejected words.
// ----------------------------------------------------------------------------
`default_nettype none

module token_bucket_rate_limiter #(
   parameter int FRACTION_BITS    = 16,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  wire logic clock,
   input  wire logic reset,
   tbrl_req_if.sink   req_chan,
   tbrl_rsp_if.source rsp_chan,
   tbrl_csr_if.sink   csr_chan
);
   import tbrl_pkg::*;

   localparam int TOK_W = CAP_W + FRACTION_BITS;
   localparam logic [DIV_W-1:0] TICKS = DIV_W'(TICKS_PER_SECOND);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EVAL, ST_GAIN, ST_CHECK, ST_DELAY, ST_DONE
   } state_type;

   state_type           state_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic [CAP_W-1:0]    cap_ff;
   logic [NOW_W-1:0]    last_ff;
   logic [TOK_W-1:0]    tokens_ff;
   logic [OP_W-1:0]     item_op_ff;
   logic [REQ_W-1:0]    item_req_ff;
   logic [NOW_W-1:0]    item_now_ff;
   logic [TOK_W-1:0]    avail_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [DELAY_W-1:0]  res_delay_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DELAY_W-1:0]  rsp_delay_ff;
   mdv_cmd_type         cmd_ff;

   mdv_status_type      mdv_sts;
   logic [PROD_W-1:0]   quot;

   logic [TOK_W-1:0]    cap_q;
   logic [TOK_W-1:0]    need;
   logic [TOK_W-1:0]    room;
   logic [NOW_W-1:0]    elapsed;
   logic                bad_count;
   logic                full;
   logic                gain_over;
   logic [TOK_W-1:0]    gain_avail;
   logic                grant;
   logic [TOK_W-1:0]    shortfall;
   logic                delay_sat;
   logic [DELAY_W-1:0]  delay_val;
   logic                slot_free;
   logic                refill_start;
   logic                delay_start;
   logic                rsp_load;

   // serial multiply/divide unit
   tbrl_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .sts   (mdv_sts),
      .quot  (quot)
   );

   // bucket arithmetic
   always_comb begin
      cap_q      = {cap_ff, {FRACTION_BITS{1'b0}}};
      need       = {item_req_ff, {FRACTION_BITS{1'b0}}};
      room       = cap_q - tokens_ff;
      elapsed    = (item_now_ff > last_ff) ? item_now_ff - last_ff : '0;
      bad_count  = (item_req_ff == '0) || (item_req_ff > cap_ff);
      full       = tokens_ff >= cap_q;
      gain_over  = (|quot[PROD_W-1:TOK_W]) || (quot[TOK_W-1:0] >= room);
      gain_avail = gain_over ? cap_q : tokens_ff + quot[TOK_W-1:0];
      grant      = avail_ff >= need;
      shortfall  = need - avail_ff;
      delay_sat  = (|quot[PROD_W-1:DELAY_W]) || (&quot[DELAY_W-1:0]);
      delay_val  = delay_sat ? DELAY_MAX
                             : quot[DELAY_W-1:0] + DELAY_W'(mdv_sts.rem_nz);
      slot_free  = !rsp_valid_ff || rsp_chan.ready;
   end

   // serial unit launches and response load
   always_comb begin
      refill_start = (state_ff == ST_EVAL) && (item_op_ff != OP_RESTART)
                   && !bad_count && !full;
      delay_start  = (state_ff == ST_CHECK) && !grant && (rate_ff != '0);
      rsp_load     = (state_ff == ST_DONE) && slot_free;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
         cap_ff  <= CAP_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_REFILL_RATE:     rate_ff <= csr_chan.data[RATE_W-1:0];
            CSR_BUCKET_CAPACITY: cap_ff  <= csr_chan.data[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // control sequencer, bucket state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         tokens_ff    <= {CAP_RESET, {FRACTION_BITS{1'b0}}};
         rsp_valid_ff <= 1'b0;
         cmd_ff.start <= 1'b0;
      end else begin
         cmd_ff.start <= refill_start || delay_start;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  item_op_ff  <= req_chan.operation;
                  item_req_ff <= req_chan.request_tokens;
                  item_now_ff <= req_chan.now_us;
                  state_ff    <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               res_delay_ff <= '0;
               if (item_op_ff == OP_RESTART) begin
                  res_status_ff <= STATUS_OK;
                  tokens_ff     <= cap_q;
                  last_ff       <= item_now_ff;
                  state_ff      <= ST_DONE;
               end else if (bad_count) begin
                  res_status_ff <= STATUS_BAD;
                  state_ff      <= ST_DONE;
               end else if (full) begin
                  res_status_ff <= STATUS_OK;
                  avail_ff      <= cap_q;
                  state_ff      <= ST_CHECK;
               end else begin
                  // refill: elapsed * rate / ticks
                  res_status_ff <= STATUS_OK;
                  cmd_ff.a      <= elapsed;
                  cmd_ff.b      <= rate_ff;
                  cmd_ff.d      <= TICKS;
                  state_ff      <= ST_GAIN;
               end
            end
            ST_GAIN: begin
               if (mdv_sts.done) begin
                  avail_ff <= gain_avail;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (grant) begin
                  tokens_ff <= avail_ff - need;
                  last_ff   <= item_now_ff;
                  state_ff  <= ST_DONE;
               end else if (rate_ff == '0) begin
                  res_status_ff <= STATUS_WAIT;
                  res_delay_ff  <= DELAY_MAX;
                  state_ff      <= ST_DONE;
               end else begin
                  // wait time: shortfall * ticks / rate, rounded up
                  cmd_ff.a     <= MUL_A_W'(shortfall);
                  cmd_ff.b     <= TICKS;
                  cmd_ff.d     <= rate_ff;
                  state_ff     <= ST_DELAY;
               end
            end
            ST_DELAY: begin
               if (mdv_sts.done) begin
                  res_status_ff <= STATUS_WAIT;
                  res_delay_ff  <= delay_val;
                  state_ff      <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (slot_free) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_delay_ff  <= res_delay_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.delay_us = rsp_delay_ff;

endmodule

`default_nettype wire
